[hdl/idea_block_encrypt_unit_assert.svh]
// Assertion macros for the checker file of the IDEA encryption unit
`ifndef IDEA_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define IDEA_BLOCK_ENCRYPT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define IEBU_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IEBU_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/iebu_pkg.sv]
// Shared constants, command struct and modular arithmetic for the IDEA encryption unit
`default_nettype none

package iebu_pkg;

  // Cipher geometry
  localparam int ROUND_COUNT  = 8;
  localparam int LANES        = 6;
  localparam int ROW_COUNT    = ROUND_COUNT + 1;
  localparam int SUBKEY_COUNT = LANES * ROUND_COUNT + 4;
  localparam int WORD_W       = 16;
  localparam int BLOCK_W      = 64;
  localparam int KEY_W        = 64;
  localparam int KEY_WORDS    = 8;
  localparam int ROT_BITS     = 25;

  // Derived widths
  localparam int ROW_W      = $clog2(ROW_COUNT);
  localparam int ROW_DATA_W = WORD_W * LANES;
  localparam int SK_CNT_W   = $clog2(SUBKEY_COUNT);
  localparam int LANE_W     = $clog2(LANES);
  localparam int KWORD_W    = $clog2(KEY_WORDS);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = CFG_INDEX_W'(1);

  // Datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_RND_A = 3'd2;
  localparam logic [OP_W-1:0] OP_RND_B = 3'd3;
  localparam logic [OP_W-1:0] OP_RND_C = 3'd4;
  localparam logic [OP_W-1:0] OP_FINAL = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               key_load;
    logic               key_step;
    logic [KWORD_W-1:0] key_word;
    logic [LANE_W-1:0]  lane;
    logic               row_we;
    logic [ROW_W-1:0]   row_addr;
  } dp_cmd_t;

  // Multiplication modulo 65537, zero standing for 65536
  function automatic logic [WORD_W-1:0] mul_mod(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [2*WORD_W-1:0] p;
    logic [WORD_W-1:0]   lo;
    logic [WORD_W-1:0]   hi;
    p  = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    lo = p[WORD_W-1:0];
    hi = p[2*WORD_W-1:WORD_W];
    if (a == '0) begin
      mul_mod = WORD_W'(1) - b;
    end else if (b == '0) begin
      mul_mod = WORD_W'(1) - a;
    end else begin
      mul_mod = lo - hi + {{(WORD_W-1){1'b0}}, (lo < hi)};
    end
  endfunction

endpackage

`default_nettype wire

[hdl/iebu_ram.sv]
// Generic single write port, single read port RAM with registered read
`default_nettype none

module iebu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/iebu_ctrl.sv]
// Controller: key schedule sweep, round sequencing and handshakes
`default_nettype none

module iebu_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            cfg_write,
  input  wire logic [iebu_pkg::CFG_INDEX_W-1:0] cfg_index,
  output      iebu_pkg::dp_cmd_t               cmd
);

  localparam logic [2:0] S_KEY_LOAD = 3'd0;
  localparam logic [2:0] S_DERIVE   = 3'd1;
  localparam logic [2:0] S_IDLE     = 3'd2;
  localparam logic [2:0] S_RND_A    = 3'd3;
  localparam logic [2:0] S_RND_B    = 3'd4;
  localparam logic [2:0] S_RND_C    = 3'd5;
  localparam logic [2:0] S_FINAL    = 3'd6;

  localparam int LAST_LANE = iebu_pkg::LANES - 1;
  localparam int LAST_SK   = iebu_pkg::SUBKEY_COUNT - 1;
  localparam int LAST_RND  = iebu_pkg::ROUND_COUNT - 1;

  logic [2:0]                      state, state_next;
  logic [iebu_pkg::SK_CNT_W-1:0]   sk_cnt, sk_cnt_next;
  logic [iebu_pkg::LANE_W-1:0]     lane, lane_next;
  logic [iebu_pkg::ROW_W-1:0]      row, row_next;
  logic [iebu_pkg::ROW_W-1:0]      round, round_next;
  logic                            out_valid_next;
  logic                            out_load;
  logic                            key_write;

  assign in_stall  = (state != S_IDLE);
  assign key_write = cfg_write &&
                     (cfg_index == iebu_pkg::REG_KEY_HIGH ||
                      cfg_index == iebu_pkg::REG_KEY_LOW);

  // Next state and commands
  always_comb begin
    state_next  = state;
    sk_cnt_next = sk_cnt;
    lane_next   = lane;
    row_next    = row;
    round_next  = round;
    out_load    = 1'b0;
    cmd         = '0;
    cmd.op      = iebu_pkg::OP_NONE;
    case (state)
      S_KEY_LOAD: begin
        cmd.key_load = 1'b1;
        sk_cnt_next  = '0;
        lane_next    = '0;
        row_next     = '0;
        state_next   = S_DERIVE;
      end
      S_DERIVE: begin
        cmd.key_step = 1'b1;
        cmd.key_word = sk_cnt[iebu_pkg::KWORD_W-1:0];
        cmd.lane     = lane;
        cmd.row_addr = row;
        cmd.row_we   = (lane == iebu_pkg::LANE_W'(LAST_LANE)) ||
                       (sk_cnt == iebu_pkg::SK_CNT_W'(LAST_SK));
        sk_cnt_next  = sk_cnt + 1'b1;
        if (lane == iebu_pkg::LANE_W'(LAST_LANE)) begin
          lane_next = '0;
          row_next  = row + 1'b1;
        end else begin
          lane_next = lane + 1'b1;
        end
        if (sk_cnt == iebu_pkg::SK_CNT_W'(LAST_SK)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.row_addr = '0;
        if (in_valid) begin
          cmd.op     = iebu_pkg::OP_LOAD;
          round_next = '0;
          state_next = S_RND_A;
        end
      end
      S_RND_A: begin
        cmd.op       = iebu_pkg::OP_RND_A;
        cmd.row_addr = round;
        state_next   = S_RND_B;
      end
      S_RND_B: begin
        cmd.op       = iebu_pkg::OP_RND_B;
        cmd.row_addr = round;
        state_next   = S_RND_C;
      end
      S_RND_C: begin
        // fetch next round's subkey row now, so the registered read has it ready for RND_A
        cmd.op       = iebu_pkg::OP_RND_C;
        cmd.row_addr = round + 1'b1;
        round_next   = round + 1'b1;
        state_next   = (round == iebu_pkg::ROW_W'(LAST_RND)) ? S_FINAL : S_RND_A;
      end
      S_FINAL: begin
        cmd.row_addr = round;
        if (!out_valid || !out_stall) begin
          cmd.op     = iebu_pkg::OP_FINAL;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_KEY_LOAD;
      end
    endcase
    // a key write restarts the schedule sweep
    if (key_write) begin
      state_next = S_KEY_LOAD;
    end
  end

  // Output valid flag
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_KEY_LOAD;
      sk_cnt    <= '0;
      lane      <= '0;
      row       <= '0;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sk_cnt    <= sk_cnt_next;
      lane      <= lane_next;
      row       <= row_next;
      round     <= round_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[hdl/iebu_dpath.sv]
// Datapath: key registers, subkey store, round unit and output register
`default_nettype none

module iebu_dpath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [iebu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [iebu_pkg::KEY_W-1:0]       cfg_data,
  input  wire logic [iebu_pkg::BLOCK_W-1:0]     plain_block,
  input  wire iebu_pkg::dp_cmd_t                cmd,
  output      logic [iebu_pkg::BLOCK_W-1:0]     cipher_block
);

  localparam int W      = iebu_pkg::WORD_W;
  localparam int ROT_W  = 2 * iebu_pkg::KEY_W;
  localparam int ROW_DW = iebu_pkg::ROW_DATA_W;

  logic [iebu_pkg::KEY_W-1:0] key_high;
  logic [iebu_pkg::KEY_W-1:0] key_low;
  logic [ROT_W-1:0]           rot_key;
  logic [W-1:0]               key_words [iebu_pkg::KEY_WORDS];
  logic [W-1:0]               sk;
  logic [ROW_DW-1:0]          row_acc;
  logic [ROW_DW-1:0]          row_wdata;
  logic [ROW_DW-1:0]          row_rdata;
  logic [W-1:0]               k [iebu_pkg::LANES];
  logic [W-1:0]               x0, x1, x2, x3, t;
  logic [W-1:0]               m0a, m0b, p0, p1, a2;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        iebu_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        iebu_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Current subkey taken from the rotating key
  always_comb begin
    for (int i = 0; i < iebu_pkg::KEY_WORDS; i++) begin
      key_words[i] = rot_key[ROT_W-1-W*i -: W];
    end
    sk = key_words[cmd.key_word];
  end

  // Row assembly: one subkey per lane
  always_comb begin
    for (int i = 0; i < iebu_pkg::LANES; i++) begin
      row_wdata[ROW_DW-1-W*i -: W] = (cmd.lane == iebu_pkg::LANE_W'(i)) ?
                                     sk : row_acc[ROW_DW-1-W*i -: W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      rot_key <= {key_high, key_low};
    end else if (cmd.key_step &&
                 cmd.key_word == iebu_pkg::KWORD_W'(iebu_pkg::KEY_WORDS - 1)) begin
      rot_key <= {rot_key[ROT_W-1-iebu_pkg::ROT_BITS:0],
                  rot_key[ROT_W-1 -: iebu_pkg::ROT_BITS]};
    end
    if (cmd.key_step) begin
      row_acc <= row_wdata;
    end
  end

  // Subkey store, one round's six subkeys to a row, the output transform's four in the last
  iebu_ram #(
    .WIDTH (ROW_DW),
    .DEPTH (iebu_pkg::ROW_COUNT)
  ) u_subkeys (
    .clk     (clk),
    .we      (cmd.row_we),
    .wr_addr (cmd.row_addr),
    .wr_data (row_wdata),
    .rd_addr (cmd.row_addr),
    .rd_data (row_rdata)
  );

  always_comb begin
    for (int i = 0; i < iebu_pkg::LANES; i++) begin
      k[i] = row_rdata[ROW_DW-1-W*i -: W];
    end
  end

  // Modular multipliers: the first is shared by the round steps, the second is fixed on x3 and k[3]
  always_comb begin
    case (cmd.op)
      iebu_pkg::OP_RND_B: begin
        m0a = x0 ^ x2;
        m0b = k[4];
      end
      iebu_pkg::OP_RND_C: begin
        m0a = t + (x1 ^ x3);
        m0b = k[5];
      end
      default: begin
        m0a = x0;
        m0b = k[0];
      end
    endcase
    p0 = iebu_pkg::mul_mod(m0a, m0b);
    p1 = iebu_pkg::mul_mod(x3, k[3]);
    a2 = t + p0;
  end

  // Round state
  always_ff @(posedge clk) begin
    case (cmd.op)
      iebu_pkg::OP_LOAD: begin
        x0 <= plain_block[4*W-1 -: W];
        x1 <= plain_block[3*W-1 -: W];
        x2 <= plain_block[2*W-1 -: W];
        x3 <= plain_block[W-1:0];
      end
      iebu_pkg::OP_RND_A: begin
        x0 <= p0;
        x1 <= x1 + k[1];
        x2 <= x2 + k[2];
        x3 <= p1;
      end
      iebu_pkg::OP_RND_B: begin
        t <= p0;
      end
      iebu_pkg::OP_RND_C: begin
        x0 <= x0 ^ p0;
        x3 <= x3 ^ a2;
        x1 <= x2 ^ p0;
        x2 <= a2 ^ x1;
      end
      iebu_pkg::OP_FINAL: begin
        cipher_block <= {p0, x2 + k[1], x1 + k[2], p1};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/idea_block_encrypt_unit.sv]
// IDEA block encryption unit: 64-bit block under a 128-bit key
// An item is taken only while the block is idle and runs eight rounds on one
// shared round unit, because each round holds three dependent multiplications
// modulo 65537 and there is a register after each; the output transform
// follows the last round. The result sits in an output register, so the next
// item is taken while it waits. After reset and after each write to a key
// register the subkey store is rebuilt, one subkey a cycle, and input is
// stalled until the rebuild is done.
`default_nettype none

module idea_block_encrypt_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [iebu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [iebu_pkg::KEY_W-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [iebu_pkg::BLOCK_W-1:0]     plain_block,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [iebu_pkg::BLOCK_W-1:0]     cipher_block
);

  iebu_pkg::dp_cmd_t cmd;

  iebu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cmd       (cmd)
  );

  iebu_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .plain_block  (plain_block),
    .cmd          (cmd),
    .cipher_block (cipher_block)
  );

endmodule

`default_nettype wire

[hdl/iebu_checker.sv]
// Port-level checks for the IDEA encryption unit, bound to the top level
`default_nettype none

`include "idea_block_encrypt_unit_assert.svh"

module iebu_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cfg_write,
  input wire logic [iebu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [iebu_pkg::BLOCK_W-1:0]     cipher_block
);

  // A stalled result holds
  `IEBU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cipher_block), "stalled result item changed")

  // A key write starts the schedule sweep, so input stalls
  `IEBU_ASSERT_NEXT(a_key_stall, clk, rst, cfg_write && (cfg_index == iebu_pkg::REG_KEY_HIGH || cfg_index == iebu_pkg::REG_KEY_LOW), in_stall, "input taken during subkey rebuild")

  // One item at a time
  `IEBU_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall, "second item taken while busy")

  // No result straight after an item is taken
  `IEBU_ASSERT_NEXT(a_no_early, clk, rst, in_valid && !in_stall, !$rose(out_valid), "result item too early")

endmodule

bind idea_block_encrypt_unit iebu_checker u_iebu_checker (.*);

`default_nettype wire
